[hw/rtl/ftr_pkg.sv]
// ----------------------------------------------------------------------------
// ftr_pkg: shared types and constants for the framed transmit ring
// Beat structs, command struct, register indexes and the CRC-8 fold.
// ----------------------------------------------------------------------------
package ftr_pkg;

  // Ring size in bytes; the 11-bit count fields of out_item_t are sized for it
  localparam int unsigned RING_DEPTH = 1024;

  typedef enum logic [1:0] {
    OP_RAW     = 2'd0,
    OP_BEGIN   = 2'd1,
    OP_PAYLOAD = 2'd2,
    OP_DRAIN   = 2'd3
  } opcode_e;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd3;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h55;
  localparam logic [7:0] MAX_PAYLOAD_RST = 8'hFF;

  localparam logic [8:0] FRAME_OVERHEAD = 9'd6;
  localparam logic [7:0] CRC_POLY       = 8'h07;
  localparam logic [7:0] CRC_TOP        = 8'h80;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic [7:0] frame_id;
    logic [7:0] frame_length;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic [10:0] pending_bytes;
    logic [10:0] free_bytes;
    logic [31:0] byte_drops;
    logic [31:0] frame_drop_count;
    logic [7:0]  last_sequence;
  } out_item_t;

  typedef struct packed {
    logic       enable;
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] max_payload;
  } cfg_t;

  // Classified command handed from the front to the back
  typedef struct packed {
    opcode_e    op;
    logic [7:0] data;
    logic [7:0] id;
    logic [7:0] len;
    logic [8:0] total;     // overhead plus payload
    logic       too_long;  // length above max_payload
  } cmd_t;

  function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_TOP) != 8'd0) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

[hw/rtl/framed_tx_ring_with_crc8_top.sv]
// ----------------------------------------------------------------------------
// framed_tx_ring_with_crc8_top: transmit byte ring with CRC-8 framing
// Producer operations and drain ticks in, one status beat out per operation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (push/full) takes one operation beat: raw byte, frame
//   begin, payload byte or drain tick. Output channel (empty/pop) returns
//   exactly one status beat per operation, in order: accepted flag, the
//   drained byte, ring occupancy and the drop counters after the operation.
//   Config is a plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i); write it
//   only while no operation is in flight.
//   A frame begin writes sync, sync, sequence, id and length bytes into the
//   ring (and the CRC byte too at length zero); a payload beat that closes
//   a frame also writes the CRC byte. The executor takes a new beat only
//   after the last one's status is registered. Frame bytes go through the
//   single ring write port, which stores one frame byte per cycle.
//   A two-entry command queue takes input beats while the executor works.
//   If pop stays low the executor holds its finished beat and stops; the
//   input queue keeps accepting until it fills.
//   Reset empties the ring, clears pointers, counters and sequence, sets
//   enable to 0 and the other registers to their defaults. No clearing pass.
// ----------------------------------------------------------------------------
module framed_tx_ring_with_crc8_top import ftr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  in_item_t              in_i,
  output logic                  empty,
  input  logic                  pop,
  output out_item_t             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t cfg_q;
  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  // Config registers; only the addressed one changes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable      <= 1'b0;
      cfg_q.sync_first  <= SYNC_FIRST_RST;
      cfg_q.sync_second <= SYNC_SECOND_RST;
      cfg_q.max_payload <= MAX_PAYLOAD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ENABLE:      cfg_q.enable      <= cfg_wdata_i[0];
        CFG_SYNC_FIRST:  cfg_q.sync_first  <= cfg_wdata_i;
        CFG_SYNC_SECOND: cfg_q.sync_second <= cfg_wdata_i;
        CFG_MAX_PAYLOAD: cfg_q.max_payload <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Front: decode and queue operation beats
  ftr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .in_i          (in_i),
    .max_payload_i (cfg_q.max_payload),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  // Back: ring writes/reads, framing, CRC and status beat
  ftr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .out_o       (out_o)
  );

endmodule

[hw/rtl/ftr_ram.sv]
// ----------------------------------------------------------------------------
// ftr_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ftr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/ftr_front.sv]
// ----------------------------------------------------------------------------
// ftr_front: input side of the transmit ring
// Decodes each input beat into a command and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module ftr_front import ftr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  in_item_t   in_i,
  input  logic [7:0] max_payload_i,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o,
  input  logic       cmd_pop_i
);

  cmd_t       slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  cmd_t       cmd_new;
  logic       do_push;

  always_comb begin
    cmd_new.op       = opcode_e'(in_i.opcode);
    cmd_new.data     = in_i.data_byte;
    cmd_new.id       = in_i.frame_id;
    cmd_new.len      = in_i.frame_length;
    cmd_new.total    = FRAME_OVERHEAD + {1'b0, in_i.frame_length};
    cmd_new.too_long = in_i.frame_length > max_payload_i;
  end

  assign full        = (cnt_q == 2'd2);
  assign do_push     = push && !full;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wp_q <= ~wp_q;
      end
      if (cmd_pop_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, cmd_pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wp_q] <= cmd_new;
    end
  end

endmodule

[hw/rtl/ftr_back.sv]
// ----------------------------------------------------------------------------
// ftr_back: ring executor
// Sequences ring writes and reads for each command, keeps the ring pointers,
// counters and CRC, and holds the result beat in an output register.
// ----------------------------------------------------------------------------
module ftr_back import ftr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_o
);

  localparam int unsigned PW = $clog2(2 * RING_DEPTH);
  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam logic [PW-1:0] DEPTH_P = PW'(RING_DEPTH);
  localparam logic [PW-1:0] LAST_P  = PW'(2 * RING_DEPTH - 1);
  localparam logic [PW:0]   SPAN_X  = (PW+1)'(2 * RING_DEPTH);

  localparam logic [2:0] STEP_SYNC1 = 3'd0;
  localparam logic [2:0] STEP_SYNC2 = 3'd1;
  localparam logic [2:0] STEP_SEQ   = 3'd2;
  localparam logic [2:0] STEP_ID    = 3'd3;
  localparam logic [2:0] STEP_LEN   = 3'd4;
  localparam logic [2:0] STEP_CRC   = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_WRITE  = 3'b010,
    S_REPORT = 3'b100
  } state_e;

  function automatic logic [PW-1:0] pos_next(input logic [PW-1:0] p);
    return (p == LAST_P) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [AW-1:0] pos_idx(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    r = (p >= DEPTH_P) ? p - DEPTH_P : p;
    return r[AW-1:0];
  endfunction

  function automatic logic [PW-1:0] pos_diff(input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic [PW:0] t;
    t = {1'b0, a} + SPAN_X - {1'b0, b};
    return (a >= b) ? a - b : t[PW-1:0];
  endfunction

  state_e        state_q, state_d;
  logic [PW-1:0] wh_q, wh_d, ph_q, ph_d, rt_q, rt_d;
  logic [31:0]   dropb_q, dropb_d, dropf_q, dropf_d;
  logic [7:0]    seq_q, seq_d, crc_q, crc_d, left_q, left_d;
  logic          open_q, open_d;
  logic [2:0]    step_q, step_d;
  logic [7:0]    id_q, id_d, len_q, len_d;
  logic          acc_q, acc_d, txv_q, txv_d;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_q, out_d;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata, ram_rdata;
  logic [PW-1:0] used, pend, free_cnt;

  assign used     = pos_diff(wh_q, rt_q);
  assign pend     = pos_diff(ph_q, rt_q);
  assign free_cnt = DEPTH_P - used;

  ftr_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (pos_idx(rt_q)),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    wh_d        = wh_q;
    ph_d        = ph_q;
    rt_d        = rt_q;
    dropb_d     = dropb_q;
    dropf_d     = dropf_q;
    seq_d       = seq_q;
    crc_d       = crc_q;
    left_d      = left_q;
    open_d      = open_q;
    step_d      = step_q;
    id_d        = id_q;
    len_d       = len_q;
    acc_d       = acc_q;
    txv_d       = txv_q;
    out_valid_d = out_valid_q && !pop;
    out_d       = out_q;
    cmd_pop_o   = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = pos_idx(wh_q);
    ram_wdata   = cmd_i.data;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          acc_d     = 1'b0;
          txv_d     = 1'b0;
          state_d   = S_REPORT;
          case (cmd_i.op)
            OP_DRAIN: begin
              if (pend != '0) begin
                ram_re = 1'b1;
                rt_d   = pos_next(rt_q);
                txv_d  = 1'b1;
              end
            end
            OP_RAW: begin
              if (cfg_i.enable && !open_q) begin
                if (free_cnt != '0) begin
                  ram_we = 1'b1;
                  wh_d   = pos_next(wh_q);
                  ph_d   = pos_next(wh_q);
                  acc_d  = 1'b1;
                end else begin
                  dropb_d = dropb_q + 32'd1;
                end
              end
            end
            OP_BEGIN: begin
              if (cfg_i.enable && !open_q && !cmd_i.too_long) begin
                if (32'(free_cnt) < 32'(cmd_i.total)) begin
                  dropb_d = dropb_q + 32'(cmd_i.total);
                  dropf_d = dropf_q + 32'd1;
                end else begin
                  acc_d   = 1'b1;
                  open_d  = 1'b1;
                  left_d  = cmd_i.len;
                  id_d    = cmd_i.id;
                  len_d   = cmd_i.len;
                  step_d  = STEP_SYNC1;
                  state_d = S_WRITE;
                end
              end
            end
            OP_PAYLOAD: begin
              if (cfg_i.enable && open_q) begin
                ram_we = 1'b1;
                wh_d   = pos_next(wh_q);
                crc_d  = crc8_fold(crc_q, cmd_i.data);
                left_d = left_q - 8'd1;
                acc_d  = 1'b1;
                if (left_q == 8'd1) begin
                  step_d  = STEP_CRC;
                  state_d = S_WRITE;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_WRITE: begin
        ram_we = 1'b1;
        wh_d   = pos_next(wh_q);
        step_d = step_q + 3'd1;
        case (step_q)
          STEP_SYNC1: ram_wdata = cfg_i.sync_first;
          STEP_SYNC2: ram_wdata = cfg_i.sync_second;
          STEP_SEQ: begin
            ram_wdata = seq_q;
            crc_d     = crc8_fold(8'd0, seq_q);
          end
          STEP_ID: begin
            ram_wdata = id_q;
            crc_d     = crc8_fold(crc_q, id_q);
          end
          STEP_LEN: begin
            ram_wdata = len_q;
            crc_d     = crc8_fold(crc_q, len_q);
            if (len_q != 8'd0) begin
              state_d = S_REPORT;
            end
          end
          STEP_CRC: begin
            // frame complete: publish it as a whole
            ram_wdata = crc_q;
            ph_d      = pos_next(wh_q);
            seq_d     = seq_q + 8'd1;
            open_d    = 1'b0;
            left_d    = 8'd0;
            state_d   = S_REPORT;
          end
          default: begin
            ram_we  = 1'b0;
            wh_d    = wh_q;
            state_d = S_REPORT;
          end
        endcase
      end

      S_REPORT: begin
        if (!out_valid_q || pop) begin
          out_valid_d            = 1'b1;
          out_d.accepted         = acc_q;
          out_d.tx_valid         = txv_q;
          out_d.tx_byte          = txv_q ? ram_rdata : 8'd0;
          out_d.pending_bytes    = 11'(pend);
          out_d.free_bytes       = 11'(free_cnt);
          out_d.byte_drops       = dropb_q;
          out_d.frame_drop_count = dropf_q;
          out_d.last_sequence    = seq_q - 8'd1;
          state_d                = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wh_q        <= '0;
      ph_q        <= '0;
      rt_q        <= '0;
      dropb_q     <= '0;
      dropf_q     <= '0;
      seq_q       <= '0;
      crc_q       <= '0;
      left_q      <= '0;
      open_q      <= 1'b0;
      step_q      <= STEP_SYNC1;
      acc_q       <= 1'b0;
      txv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wh_q        <= wh_d;
      ph_q        <= ph_d;
      rt_q        <= rt_d;
      dropb_q     <= dropb_d;
      dropf_q     <= dropf_d;
      seq_q       <= seq_d;
      crc_q       <= crc_d;
      left_q      <= left_d;
      open_q      <= open_d;
      step_q      <= step_d;
      acc_q       <= acc_d;
      txv_q       <= txv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    len_q <= len_d;
    out_q <= out_d;
  end

  assign empty = !out_valid_q;
  assign out_o = out_q;

`ifndef SYNTHESIS
  // an open frame outside S_WRITE always holds unpublished bytes
  a_open_has_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (open_q && (state_q != S_WRITE)) |-> (wh_q != ph_q))
    else $error("open frame with no unpublished bytes");

  a_left_needs_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (left_q != 8'd0) |-> open_q)
    else $error("payload count left without open frame");

  a_used_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used <= DEPTH_P)
    else $error("ring over-filled");

  a_write_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE) |-> open_q)
    else $error("frame bytes written with no open frame");
`endif

endmodule

[tb/framed_tx_ring_with_crc8_top_test.sv]
// ----------------------------------------------------------------------------
// framed_tx_ring_with_crc8_top_test: self-checking bench for the framed tx ring
// Drives raw, frame, payload and drain beats with random idling on both
// queue sides. Every status beat is checked against an untimed model of the
// ring, the CRC-8 framing and the drop counters.
// ----------------------------------------------------------------------------
module framed_tx_ring_with_crc8_top_test;
  import ftr_pkg::*;

  localparam int unsigned POS_W       = $clog2(2 * RING_DEPTH);
  // The limit covers the worst quiet stretch: sender gap, frame begin
  // latency, receiver stall and a register update, with a wide margin.
  localparam int unsigned STALL_LIMIT = 400;
  localparam int unsigned MAX_REPORTS = 40;

  // --------------------------------------------------------------------------
  // Untimed model of the ring. Positions run modulo twice the depth so that
  // full and empty stay apart; the ring index is the position modulo depth.
  // --------------------------------------------------------------------------
  class frame_ring_scoreboard;
    logic [7:0]       ring_mem [RING_DEPTH];
    logic [POS_W-1:0] commit_ptr;   // end of published bytes
    logic [POS_W-1:0] fill_ptr;     // next byte written
    logic [POS_W-1:0] drain_ptr;    // next byte handed out by a drain
    logic [31:0]      lost_bytes;
    logic [31:0]      lost_frames;
    logic [7:0]       seq_no;
    logic [7:0]       crc_acc;
    logic [7:0]       bytes_to_go;
    bit               in_frame;
    cfg_t             cfg;
    out_item_t        status_due [$];
    int unsigned      errors;

    function new();
      commit_ptr  = '0;
      fill_ptr    = '0;
      drain_ptr   = '0;
      lost_bytes  = '0;
      lost_frames = '0;
      seq_no      = '0;
      crc_acc     = '0;
      bytes_to_go = '0;
      in_frame    = 1'b0;
      errors      = 0;
      cfg         = '{1'b0, SYNC_FIRST_RST, SYNC_SECOND_RST, MAX_PAYLOAD_RST};
    endfunction

    function logic [POS_W-1:0] space_left();
      return POS_W'(RING_DEPTH) - (fill_ptr - drain_ptr);
    endfunction

    function logic [POS_W-1:0] pending_now();
      return commit_ptr - drain_ptr;
    endfunction

    // MSB-first CRC-8, poly 0x07
    function logic [7:0] crc_step(logic [7:0] acc, logic [7:0] b);
      logic [7:0] r;
      r = acc ^ b;
      repeat (8) r = {r[6:0], 1'b0} ^ (r[7] ? CRC_POLY : 8'h00);
      return r;
    endfunction

    function void put(logic [7:0] b);
      ring_mem[fill_ptr % RING_DEPTH] = b;
      fill_ptr++;
    endfunction

    // CRC byte closes the frame and publishes all of it
    function void seal();
      put(crc_acc);
      commit_ptr  = fill_ptr;
      seq_no++;
      in_frame    = 1'b0;
      bytes_to_go = '0;
    endfunction

    // Apply one accepted operation beat and queue the status it must return
    function void take_op(in_item_t it);
      out_item_t  want;
      logic [8:0] need;
      want = '0;
      case (opcode_e'(it.opcode))
        OP_DRAIN: begin
          if (commit_ptr != drain_ptr) begin
            want.tx_byte  = ring_mem[drain_ptr % RING_DEPTH];
            want.tx_valid = 1'b1;
            drain_ptr++;
          end
        end
        OP_RAW: begin
          if (cfg.enable && !in_frame) begin
            if (space_left() != 0) begin
              put(it.data_byte);
              commit_ptr    = fill_ptr;
              want.accepted = 1'b1;
            end else begin
              lost_bytes++;
            end
          end
        end
        OP_BEGIN: begin
          if (cfg.enable && !in_frame && it.frame_length <= cfg.max_payload) begin
            need = FRAME_OVERHEAD + {1'b0, it.frame_length};
            if (space_left() < need) begin
              lost_bytes  += 32'(need);
              lost_frames++;
            end else begin
              put(cfg.sync_first);
              put(cfg.sync_second);
              put(seq_no);
              put(it.frame_id);
              put(it.frame_length);
              crc_acc       = crc_step(crc_step(crc_step(8'h00, seq_no), it.frame_id),
                                       it.frame_length);
              bytes_to_go   = it.frame_length;
              in_frame      = 1'b1;
              want.accepted = 1'b1;
              if (it.frame_length == 0) seal();
            end
          end
        end
        OP_PAYLOAD: begin
          if (cfg.enable && in_frame) begin
            put(it.data_byte);
            crc_acc = crc_step(crc_acc, it.data_byte);
            bytes_to_go--;
            want.accepted = 1'b1;
            if (bytes_to_go == 0) seal();
          end
        end
        default: begin
        end
      endcase
      want.pending_bytes    = pending_now();
      want.free_bytes       = space_left();
      want.byte_drops       = lost_bytes;
      want.frame_drop_count = lost_frames;
      want.last_sequence    = seq_no - 8'd1;
      status_due.push_back(want);
    endfunction

    function void diff(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_status(out_item_t got);
      out_item_t want;
      if (status_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: status beat with nothing expected, actual %h", $time, got);
        return;
      end
      want = status_due.pop_front();
      diff("accepted", want.accepted, got.accepted);
      diff("tx_valid", want.tx_valid, got.tx_valid);
      diff("tx_byte", want.tx_byte, got.tx_byte);
      diff("pending_bytes", want.pending_bytes, got.pending_bytes);
      diff("free_bytes", want.free_bytes, got.free_bytes);
      diff("byte_drops", want.byte_drops, got.byte_drops);
      diff("frame_drop_count", want.frame_drop_count, got.frame_drop_count);
      diff("last_sequence", want.last_sequence, got.last_sequence);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  push      = 1'b0;
  logic                  pop       = 1'b0;
  logic                  full;
  logic                  empty;
  in_item_t              in_beat   = '0;
  out_item_t             out_beat;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  frame_ring_scoreboard sb = new();

  int unsigned tx_calm = 0;       // beats left in a no-idle stretch, sender
  int unsigned rx_calm = 0;       // same for the receiver
  int unsigned stall_cycles = 0;

  always #4 clk_i = ~clk_i;

  framed_tx_ring_with_crc8_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_i       (in_beat),
    .empty      (empty),
    .pop        (pop),
    .out_o      (out_beat),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  // Idle cycles before the next beat; now and then a run of back-to-back beats
  function automatic int unsigned draw_gap(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm = $urandom_range(4, 40);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  // Push one beat. push stays high after the handshake so a back-to-back beat
  // never sees it dropped and raised in the same step; the next caller
  // either drives a new beat or lowers it.
  task automatic push_op(input in_item_t it);
    int unsigned gap;
    gap = draw_gap(tx_calm);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    in_beat <= it;
    do @(posedge clk_i); while (full);
    sb.take_op(it);
  endtask

  task automatic send_op(opcode_e op, logic [7:0] data, logic [7:0] id, logic [7:0] len);
    in_item_t it;
    it.opcode       = op;
    it.data_byte    = data;
    it.frame_id     = id;
    it.frame_length = len;
    push_op(it);
  endtask

  task automatic send_noise();
    send_op(opcode_e'(2'($urandom_range(0, 3))), rnd8(), rnd8(), rnd8());
  endtask

  // A frame begin followed by its payload, with the odd drain tick and a few
  // refused raw/begin beats mixed in. Stops once no frame is open or when disabled.
  task automatic send_frame(logic [7:0] len);
    int unsigned roll;
    send_op(OP_BEGIN, rnd8(), rnd8(), len);
    while (sb.in_frame && sb.cfg.enable) begin
      roll = $urandom_range(0, 99);
      if (roll < 8)
        send_op(OP_DRAIN, rnd8(), rnd8(), rnd8());
      else if (roll < 13)
        send_op(roll[0] ? OP_RAW : OP_BEGIN, rnd8(), rnd8(), rnd8());
      else
        send_op(OP_PAYLOAD, rnd8(), rnd8(), rnd8());
    end
  endtask

  // Weighted traffic in percent; whatever is left over goes to random beats.
  // A frame left open by a random begin is mostly fed to completion.
  // Stops early once free space or pending bytes fall to the given marks
  // (-1 turns a mark off).
  task automatic traffic(int unsigned ops, int unsigned w_raw, int unsigned w_drain,
                         int unsigned w_frame, int unsigned frame_max,
                         int stop_free, int stop_pending);
    int unsigned roll;
    for (int unsigned i = 0; i < ops; i++) begin
      if (int'(sb.space_left()) <= stop_free || int'(sb.pending_now()) <= stop_pending)
        break;
      roll = $urandom_range(0, 99);
      if (sb.in_frame && roll < 80)
        send_op(OP_PAYLOAD, rnd8(), rnd8(), rnd8());
      else if (roll < w_raw)
        send_op(OP_RAW, rnd8(), rnd8(), rnd8());
      else if (roll < w_raw + w_drain)
        send_op(OP_DRAIN, rnd8(), rnd8(), rnd8());
      else if (roll < w_raw + w_drain + w_frame)
        send_frame($urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(0, frame_max)));
      else
        send_noise();
    end
  endtask

  // Register update, only once every status beat is back. All four
  // registers are written on consecutive edges; the enable write carries
  // random upper bits, which must be ignored.
  task automatic apply_cfg(logic en, logic [7:0] s1, logic [7:0] s2, logic [7:0] mx);
    push <= 1'b0;
    while (sb.status_due.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_ENABLE;
    cfg_wdata <= {7'($urandom_range(0, 127)), en};
    @(posedge clk_i);
    cfg_idx   <= CFG_SYNC_FIRST;
    cfg_wdata <= s1;
    @(posedge clk_i);
    cfg_idx   <= CFG_SYNC_SECOND;
    cfg_wdata <= s2;
    @(posedge clk_i);
    cfg_idx   <= CFG_MAX_PAYLOAD;
    cfg_wdata <= mx;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    sb.cfg = '{en, s1, s2, mx};
  endtask

  // --------------------------------------------------------------------------
  // Status side: pop with random stalls, check each beat taken
  // --------------------------------------------------------------------------
  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap(rx_calm);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      sb.check_status(out_beat);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without a handshake on either side means a hang
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty))
      stall_cycles <= 0;
    else if (rst_ni)
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Out of reset the block is disabled: drains on an empty ring return
    // nothing, producer beats are refused.
    send_op(OP_DRAIN, rnd8(), rnd8(), rnd8());
    send_op(OP_RAW, 8'h5A, rnd8(), rnd8());
    send_op(OP_BEGIN, rnd8(), rnd8(), 8'd0);

    apply_cfg(1'b1, 8'hFF, 8'h00, 8'hFF);
    send_op(OP_RAW, 8'h00, 8'h00, 8'h00);
    send_op(OP_RAW, 8'hFF, 8'hFF, 8'hFF);
    send_op(OP_PAYLOAD, rnd8(), rnd8(), rnd8());   // no frame open
    send_op(OP_BEGIN, rnd8(), 8'hFF, 8'd0);        // empty frame, sealed at once
    send_op(OP_BEGIN, rnd8(), 8'h00, 8'd2);
    send_op(OP_RAW, rnd8(), rnd8(), rnd8());       // refused, frame open
    send_op(OP_BEGIN, rnd8(), rnd8(), 8'd1);       // refused, frame open
    send_op(OP_PAYLOAD, 8'hFF, rnd8(), rnd8());

    // Disable with the frame still open: payload refused, drains still go
    apply_cfg(1'b0, 8'hFF, 8'h00, 8'd254);
    send_op(OP_PAYLOAD, 8'h00, rnd8(), rnd8());
    send_op(OP_DRAIN, rnd8(), rnd8(), rnd8());

    // Re-enable: the open frame picks up where it stopped
    apply_cfg(1'b1, 8'hAA, 8'h55, 8'd254);
    send_op(OP_PAYLOAD, 8'h00, rnd8(), rnd8());
    send_op(OP_BEGIN, rnd8(), rnd8(), 8'hFF);      // one above max_payload
    repeat (6) send_op(OP_DRAIN, rnd8(), rnd8(), rnd8());

    apply_cfg(1'b1, 8'h00, 8'hFF, 8'd0);
    send_op(OP_BEGIN, rnd8(), rnd8(), 8'd1);       // too long at max 0
    send_op(OP_BEGIN, rnd8(), rnd8(), 8'd0);
    send_op(OP_DRAIN, rnd8(), rnd8(), rnd8());

    // Fill the ring: one longer frame, then mostly empty frames (six bytes
    // per beat) until only a few bytes are free. The write index wraps.
    apply_cfg(1'b1, SYNC_FIRST_RST, SYNC_SECOND_RST, MAX_PAYLOAD_RST);
    send_frame(8'd40);
    traffic(260, 10, 5, 85, 0, 8, -1);

    // Churn near full: raw drops, frame drops and too-long refusals
    apply_cfg(1'b1, 8'h00, 8'hFF, 8'd3);
    traffic(120, 35, 25, 25, 8, -1, -1);

    // Drain part of the backlog
    apply_cfg(1'b1, 8'hFF, 8'h00, 8'd12);
    traffic(120, 2, 95, 3, 3, -1, 0);

    // Refill with short frames
    apply_cfg(1'b1, rnd8(), rnd8(), 8'($urandom_range(1, 254)));
    traffic(40, 15, 15, 70, 8, 8, -1);

    // Disabled: everything but drains is refused
    apply_cfg(1'b0, rnd8(), rnd8(), rnd8());
    traffic(40, 25, 25, 25, 255, -1, -1);

    // Mixed traffic to finish
    apply_cfg(1'b1, rnd8(), rnd8(), MAX_PAYLOAD_RST);
    traffic(100, 25, 30, 30, 20, -1, -1);

    // Let the last status beats come back, then give the block time to show
    // any stray beat.
    push <= 1'b0;
    while (sb.status_due.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    if (sb.errors == 0 && sb.status_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
